FILE: rtl/core/sha1_message_hasher_defines.svh
// assertion macros for the sha-1 message hasher
// used by files that assert; expects clk_i and rst_ni in scope
`ifndef SHA1_MESSAGE_HASHER_DEFINES_SVH
`define SHA1_MESSAGE_HASHER_DEFINES_SVH

// same-cycle implication
`define SHA1MH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SHA1MH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/sha1mh_pkg.sv
// shared types and constants for the sha-1 message hasher
// no dependencies
`default_nettype none

package sha1mh_pkg;

  localparam int unsigned LenW   = 61;
  localparam int unsigned RndW   = 7;
  localparam int unsigned PosW   = 6;
  localparam int unsigned IdxW   = 3;

  localparam logic OpAbsorb = 1'b0;
  localparam logic OpFinish = 1'b1;

  typedef logic [31:0] word_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
    word_t e;
  } work_t;

  localparam work_t HInit = '{
    a: 32'h67452301,
    b: 32'hEFCDAB89,
    c: 32'h98BADCFE,
    d: 32'h10325476,
    e: 32'hC3D2E1F0
  };

  localparam word_t K0 = 32'h5A827999;
  localparam word_t K1 = 32'h6ED9EBA1;
  localparam word_t K2 = 32'h8F1BBCDC;
  localparam word_t K3 = 32'hCA62C1D6;

  localparam logic [RndW-1:0] Stage1Start = 7'd20;
  localparam logic [RndW-1:0] Stage2Start = 7'd40;
  localparam logic [RndW-1:0] Stage3Start = 7'd60;
  localparam logic [RndW-1:0] LastRound   = 7'd79;

  localparam logic [PosW-1:0] LenPos  = 6'd56;
  localparam logic [PosW-1:0] LastPos = 6'd63;

  localparam logic [7:0] PadByte = 8'h80;

  localparam logic [IdxW-1:0] IdxA = 3'd0;
  localparam logic [IdxW-1:0] IdxB = 3'd1;
  localparam logic [IdxW-1:0] IdxC = 3'd2;
  localparam logic [IdxW-1:0] IdxD = 3'd3;
  localparam logic [IdxW-1:0] IdxE = 3'd4;

endpackage

`default_nettype wire

FILE: rtl/core/sha1_message_hasher.sv
// sha-1 message hasher top level: byte buffer, padding sequencer, round loop
// depends on sha1mh_pkg, sha1mh_round and sha1_message_hasher_defines.svh
//
// usage:
//   input channel (in_valid_i / in_stall_o) carries operation_i and data_byte_i.
//   operation 0 absorbs one byte, operation 1 finishes the message.
//   output channel (out_valid_o / out_stall_i) carries five digest beats,
//   word_index_o 0..4, last_word_o on the fifth.
// sequence:
//   an absorb beat stores one byte; the beat that fills a 64-byte block adds
//   a compression (80 rounds through the one round unit, 1 chaining add).
//   a finish beat pads one byte per cycle up to byte 56,
//   writes the length, and runs one or two compressions,
//   then shows the digest beats one per cycle while out_stall_i is low.
// in_stall_o is high whenever the block is busy or holds the digest.
// reset loads the standard initial chaining words and clears the length.
// a stalled digest beat holds until taken; after the last beat the block
// starts a new message.
`default_nettype none
`include "sha1_message_hasher_defines.svh"

module sha1_message_hasher (
  input  var logic        clk_i,
  input  var logic        rst_ni,
  input  var logic        in_valid_i,
  output var logic        in_stall_o,
  input  var logic        operation_i,
  input  var logic [7:0]  data_byte_i,
  output var logic        out_valid_o,
  input  var logic        out_stall_i,
  output var logic [31:0] digest_word_o,
  output var logic [2:0]  word_index_o,
  output var logic        last_word_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_ROUND = 3'd2;
  localparam logic [2:0] S_ADD   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]                      state_q, state_d;
  logic [sha1mh_pkg::RndW-1:0]     rnd_q, rnd_d;
  logic [sha1mh_pkg::PosW-1:0]     pad_q, pad_d;
  logic                            padm_q, padm_d;
  logic                            fin_q, fin_d;
  logic [sha1mh_pkg::IdxW-1:0]     idx_q, idx_d;
  logic [sha1mh_pkg::LenW-1:0]     len_q, len_d;
  sha1mh_pkg::work_t               h_q, h_d;
  sha1mh_pkg::work_t               work_q, work_d;
  logic [15:0][31:0]               win_q, win_d;

  sha1mh_pkg::work_t               rnd_work;
  sha1mh_pkg::word_t               w_mix;
  sha1mh_pkg::word_t               w_new;

  sha1mh_round u_round (
    .work_i  (work_q),
    .w_i     (win_q[15]),
    .round_i (rnd_q),
    .work_o  (rnd_work)
  );

  assign w_mix = win_q[2] ^ win_q[7] ^ win_q[13] ^ win_q[15];
  assign w_new = {w_mix[30:0], w_mix[31]};

  always_comb begin
    state_d = state_q;
    rnd_d   = rnd_q;
    pad_d   = pad_q;
    padm_d  = padm_q;
    fin_d   = fin_q;
    idx_d   = idx_q;
    len_d   = len_q;
    h_d     = h_q;
    work_d  = work_q;
    win_d   = win_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (operation_i == sha1mh_pkg::OpAbsorb) begin
            win_d = {win_q[15][23:0], win_q[14:0], data_byte_i};
            len_d = len_q + 61'd1;
            if (len_q[sha1mh_pkg::PosW-1:0] == sha1mh_pkg::LastPos) begin
              state_d = S_ROUND;
              rnd_d   = '0;
              work_d  = h_q;
              padm_d  = 1'b0;
              fin_d   = 1'b0;
            end
          end else begin
            win_d  = {win_q[15][23:0], win_q[14:0], sha1mh_pkg::PadByte};
            padm_d = 1'b1;
            fin_d  = 1'b0;
            if (len_q[sha1mh_pkg::PosW-1:0] == sha1mh_pkg::LastPos) begin
              state_d = S_ROUND;
              rnd_d   = '0;
              work_d  = h_q;
              pad_d   = '0;
            end else begin
              state_d = S_PAD;
              pad_d   = len_q[sha1mh_pkg::PosW-1:0] + 6'd1;
            end
          end
        end
      end
      S_PAD: begin
        if (pad_q == sha1mh_pkg::LenPos) begin
          win_d   = {win_q[13:0], len_q, 3'b000};
          fin_d   = 1'b1;
          state_d = S_ROUND;
          rnd_d   = '0;
          work_d  = h_q;
        end else begin
          win_d = {win_q[15][23:0], win_q[14:0], 8'h00};
          pad_d = pad_q + 6'd1;
          if (pad_q == sha1mh_pkg::LastPos) begin
            state_d = S_ROUND;
            rnd_d   = '0;
            work_d  = h_q;
          end
        end
      end
      S_ROUND: begin
        work_d = rnd_work;
        win_d  = {win_q[14:0], w_new};
        rnd_d  = rnd_q + 7'd1;
        if (rnd_q == sha1mh_pkg::LastRound) begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        h_d.a = h_q.a + work_q.a;
        h_d.b = h_q.b + work_q.b;
        h_d.c = h_q.c + work_q.c;
        h_d.d = h_q.d + work_q.d;
        h_d.e = h_q.e + work_q.e;
        idx_d = sha1mh_pkg::IdxA;
        if (fin_q) begin
          state_d = S_OUT;
        end else if (padm_q) begin
          state_d = S_PAD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_OUT: begin
        if (!out_stall_i) begin
          if (idx_q == sha1mh_pkg::IdxE) begin
            h_d     = sha1mh_pkg::HInit;
            len_d   = '0;
            padm_d  = 1'b0;
            fin_d   = 1'b0;
            state_d = S_IDLE;
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rnd_q   <= '0;
      pad_q   <= '0;
      padm_q  <= 1'b0;
      fin_q   <= 1'b0;
      idx_q   <= '0;
      len_q   <= '0;
      h_q     <= sha1mh_pkg::HInit;
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
      pad_q   <= pad_d;
      padm_q  <= padm_d;
      fin_q   <= fin_d;
      idx_q   <= idx_d;
      len_q   <= len_d;
      h_q     <= h_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    win_q  <= win_d;
  end

  always_comb begin
    case (idx_q)
      sha1mh_pkg::IdxA: digest_word_o = h_q.a;
      sha1mh_pkg::IdxB: digest_word_o = h_q.b;
      sha1mh_pkg::IdxC: digest_word_o = h_q.c;
      sha1mh_pkg::IdxD: digest_word_o = h_q.d;
      default:          digest_word_o = h_q.e;
    endcase
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = (state_q == S_OUT);
  assign word_index_o = idx_q;
  assign last_word_o  = (idx_q == sha1mh_pkg::IdxE);

  `SHA1MH_ASSERT_IMP(a_digest_blocks_input, out_valid_o, in_stall_o, "input open during digest")
  `SHA1MH_ASSERT_IMP(a_round_in_range, state_q == S_ROUND, rnd_q <= sha1mh_pkg::LastRound, "round count overrun")
  `SHA1MH_ASSERT_NXT(a_last_beat_restarts, out_valid_o && !out_stall_i && last_word_o, !in_stall_o && len_q == '0, "no restart after last beat")
  `SHA1MH_ASSERT_NXT(a_word_steps, out_valid_o && !out_stall_i && !last_word_o, out_valid_o && word_index_o == $past(word_index_o) + 3'd1, "digest index skipped")
  `SHA1MH_ASSERT_NXT(a_absorb_quick, in_valid_i && !in_stall_o && operation_i == sha1mh_pkg::OpAbsorb && len_q[5:0] != sha1mh_pkg::LastPos, !in_stall_o, "absorb beat stalled")

endmodule

`default_nettype wire

FILE: rtl/core/sha1mh_round.sv
// one sha-1 round: boolean function, round constant and five-word update
// depends on sha1mh_pkg
`default_nettype none

module sha1mh_round (
  input  var sha1mh_pkg::work_t               work_i,
  input  var sha1mh_pkg::word_t               w_i,
  input  var logic [sha1mh_pkg::RndW-1:0]     round_i,
  output var sha1mh_pkg::work_t               work_o
);

  sha1mh_pkg::word_t f;
  sha1mh_pkg::word_t k;
  sha1mh_pkg::word_t t;

  always_comb begin
    if (round_i < sha1mh_pkg::Stage1Start) begin
      f = (work_i.b & work_i.c) | (~work_i.b & work_i.d);
      k = sha1mh_pkg::K0;
    end else if (round_i < sha1mh_pkg::Stage2Start) begin
      f = work_i.b ^ work_i.c ^ work_i.d;
      k = sha1mh_pkg::K1;
    end else if (round_i < sha1mh_pkg::Stage3Start) begin
      f = (work_i.b & work_i.c) | (work_i.b & work_i.d) | (work_i.c & work_i.d);
      k = sha1mh_pkg::K2;
    end else begin
      f = work_i.b ^ work_i.c ^ work_i.d;
      k = sha1mh_pkg::K3;
    end
    t = {work_i.a[26:0], work_i.a[31:27]} + f + work_i.e + k + w_i;
    work_o.a = t;
    work_o.b = work_i.a;
    work_o.c = {work_i.b[1:0], work_i.b[31:2]};
    work_o.d = work_i.c;
    work_o.e = work_i.d;
  end

endmodule

`default_nettype wire
